// File: rtl/tlv8p_pkg.sv
// ----------------------------------------------------------------------------
// tlv8p_pkg
// Types and constants shared by the TLV8 chunk merging parser modules.
// ----------------------------------------------------------------------------
package tlv8p_pkg;

  localparam logic [7:0] FULL_CHUNK = 8'd255;
  localparam int unsigned MAX_RESULTS = 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] item_type;
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       value_end;
    logic       truncated_error;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// File: rtl/tlv8_chunk_merging_parser.sv
// ----------------------------------------------------------------------------
// tlv8_chunk_merging_parser
// TLV8 byte stream parser that merges 255-byte chunks of one type.
// ----------------------------------------------------------------------------
// The parser takes one raw buffer byte per clock while in_ready is high and
// turns it into zero, one or two result beats in the same cycle, which enter
// a four-entry result queue whose registers feed the output. One byte is
// accepted in every cycle while the queue has room for two beats, so with a
// ready consumer the sustained rate is one byte per clock, and the output
// port, at one beat per clock, is what sets the limit when bytes that yield
// two results come in a run.
module tlv8_chunk_merging_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_buffer_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_item_type,
  output logic [7:0] out_value_byte,
  output logic       out_byte_valid,
  output logic       out_value_end,
  output logic       out_truncated_error
);

  tlv8p_pkg::push_t   push;
  tlv8p_pkg::result_t out_res;
  logic               advance;

  assign advance = in_valid && in_ready;

  tlv8p_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .data_byte  (in_data_byte),
    .buffer_end (in_buffer_end),
    .push       (push)
  );

  tlv8p_outq u_outq (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .room_for_two (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res      (out_res)
  );

  assign out_item_type       = out_res.item_type;
  assign out_value_byte      = out_res.value_byte;
  assign out_byte_valid      = out_res.byte_valid;
  assign out_value_end       = out_res.value_end;
  assign out_truncated_error = out_res.truncated_error;

endmodule

// File: rtl/tlv8p_step.sv
// ----------------------------------------------------------------------------
// tlv8p_step
// Parser state and the per-byte decode that yields up to two result beats.
// ----------------------------------------------------------------------------
module tlv8p_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        data_byte,
  input  logic              buffer_end,
  output tlv8p_pkg::push_t  push
);

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cur_type_r, cur_type_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic       was_full_r, was_full_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       continuing_r, continuing_nxt;

  function automatic tlv8p_pkg::result_t mk(input logic [7:0] t, input logic [7:0] v,
                                            input logic vld, input logic e,
                                            input logic tr);
    tlv8p_pkg::result_t r;
    r.item_type       = t;
    r.value_byte      = v;
    r.byte_valid      = vld;
    r.value_end       = e;
    r.truncated_error = tr;
    return r;
  endfunction

  always_comb begin
    tlv8p_pkg::result_t res [2];
    logic [1:0]         n;
    logic [7:0]         rem_dec;

    res[0] = '0;
    res[1] = '0;
    n      = 2'd0;
    rem_dec = remaining_r - 8'd1;

    phase_nxt      = phase_r;
    cur_type_nxt   = cur_type_r;
    remaining_nxt  = remaining_r;
    was_full_nxt   = was_full_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    continuing_nxt = continuing_r;

    unique case (phase_r)
      PH_TYPE: begin
        if (held_valid_r && data_byte == cur_type_r && !buffer_end) begin
          continuing_nxt = 1'b1;
        end else begin
          if (held_valid_r) begin
            res[n[0]] = mk(cur_type_r, held_byte_r, 1'b1, 1'b1, 1'b0);
            n = n + 2'd1;
            held_valid_nxt = 1'b0;
          end
          continuing_nxt = 1'b0;
        end
        cur_type_nxt = data_byte;
        phase_nxt    = PH_LEN;
        if (buffer_end) begin
          res[n[0]] = mk(data_byte, 8'd0, 1'b0, 1'b1, 1'b1);
          n = n + 2'd1;
        end
      end
      PH_LEN: begin
        if (continuing_r && held_valid_r) begin
          res[n[0]] = mk(cur_type_r, held_byte_r, 1'b1, data_byte == 8'd0, 1'b0);
          n = n + 2'd1;
          held_valid_nxt = 1'b0;
        end
        continuing_nxt = 1'b0;
        if (data_byte == 8'd0) begin
          res[n[0]] = mk(cur_type_r, 8'd0, 1'b0, 1'b1, 1'b0);
          n = n + 2'd1;
          was_full_nxt = 1'b0;
          phase_nxt    = PH_TYPE;
        end else begin
          remaining_nxt = data_byte;
          was_full_nxt  = (data_byte == tlv8p_pkg::FULL_CHUNK);
          phase_nxt     = PH_VALUE;
          if (buffer_end) begin
            res[n[0]] = mk(cur_type_r, 8'd0, 1'b0, 1'b1, 1'b1);
            n = n + 2'd1;
          end
        end
      end
      default: begin
        remaining_nxt = rem_dec;
        if (rem_dec != 8'd0) begin
          res[0] = mk(cur_type_r, data_byte, 1'b1, 1'b0, 1'b0);
          n = 2'd1;
          if (buffer_end) begin
            res[1] = mk(cur_type_r, 8'd0, 1'b0, 1'b1, 1'b1);
            n = 2'd2;
          end
        end else if (was_full_r && !buffer_end) begin
          held_byte_nxt  = data_byte;
          held_valid_nxt = 1'b1;
          phase_nxt      = PH_TYPE;
        end else begin
          res[0] = mk(cur_type_r, data_byte, 1'b1, 1'b1, 1'b0);
          n = 2'd1;
          phase_nxt = PH_TYPE;
        end
      end
    endcase

    if (buffer_end) begin
      phase_nxt      = PH_TYPE;
      remaining_nxt  = 8'd0;
      was_full_nxt   = 1'b0;
      held_byte_nxt  = 8'd0;
      held_valid_nxt = 1'b0;
      continuing_nxt = 1'b0;
    end

    push.count = advance ? n : 2'd0;
    push.res0  = res[0];
    push.res1  = res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TYPE;
      cur_type_r   <= 8'd0;
      remaining_r  <= 8'd0;
      was_full_r   <= 1'b0;
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
      continuing_r <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      cur_type_r   <= cur_type_nxt;
      remaining_r  <= remaining_nxt;
      was_full_r   <= was_full_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      continuing_r <= continuing_nxt;
    end
  end

endmodule

// File: rtl/tlv8p_outq.sv
// ----------------------------------------------------------------------------
// tlv8p_outq
// Result queue that takes up to two beats per cycle and sends one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tlv8p_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  tlv8p_pkg::push_t   push,
  output logic               room_for_two,
  output logic               out_valid,
  input  logic               out_ready,
  output tlv8p_pkg::result_t out_res
);

  localparam int unsigned AW = tlv8p_pkg::QUEUE_AW;
  localparam logic [AW:0] DEPTH = (AW + 1)'(tlv8p_pkg::QUEUE_DEPTH);

  tlv8p_pkg::result_t mem [tlv8p_pkg::QUEUE_DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          pop;

  assign pop          = out_valid && out_ready;
  assign out_valid    = (count_r != '0);
  assign room_for_two = (count_r <= DEPTH - (AW + 1)'(2));
  assign out_res      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push.count);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    count_nxt  = count_r + (AW + 1)'(push.count) - (AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_r + AW'(1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
